### hdl/spcr_pkg.sv
// Shared types and constants of the spectral peak cluster reducer.
`default_nettype none
package spcr_pkg;

  // Field widths
  localparam int PW = 15;            // pitch, Q7.8
  localparam int VW = 16;            // peak volume, Q0.16
  localparam int SW = 24;            // reduced volume and volume sum, Q8.16
  localparam int WW = 39;            // weighted sum
  localparam int MW = PW + VW;       // pitch times volume
  localparam int CFGW = 24;          // widest configuration register
  localparam int CNTW = 4;           // divider step counter

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW = 1;

  localparam logic [PW-1:0] PITCH_MAX = '1;

  // Configuration register indexes
  localparam logic [1:0] CFG_JOIN  = 2'd0;
  localparam logic [1:0] CFG_PMODE = 2'd1;
  localparam logic [1:0] CFG_VMODE = 2'd2;
  localparam logic [1:0] CFG_FLOOR = 2'd3;

  // Pitch modes; any other code selects the weighted mean
  localparam logic [1:0] PM_CENTRE  = 2'd0;
  localparam logic [1:0] PM_LOUDEST = 2'd1;
  localparam logic [1:0] PM_WMEAN   = 2'd2;

  // Volume modes
  localparam logic VM_MAX = 1'b0;
  localparam logic VM_SUM = 1'b1;

  typedef struct packed {
    logic [PW-1:0] pitch;
    logic [VW-1:0] volume;
    logic          last;
    logic [MW-1:0] prod;
  } peak_t;

  typedef struct packed {
    logic  valid;
    peak_t item;
  } qhead_t;

  typedef struct packed {
    logic [PW-1:0] join_distance;
    logic [1:0]    pitch_mode;
    logic          volume_mode;
    logic [SW-1:0] volume_floor;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REDUCE,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

  typedef enum logic {
    PH_CLOSE,
    PH_FINAL
  } phase_t;

endpackage
`default_nettype wire

### hdl/spectral_peak_cluster_reduce_top.sv
// Spectral peak cluster reducer: top level with configuration registers.
//
// Usage: peaks of one frame arrive in ascending pitch order on the in_ stream,
// one per transfer, in_tlast on the frame's final peak. Each closed cluster is
// reduced to one pitch and volume and sent on the out_ stream unless its volume
// is below the floor; the frame's final result carries out_tlast, and a
// dropped final cluster is replaced by a marker with out_tuser set.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
// Flow: a peak passes the input stage register and the queue. A peak
// that only joins a cluster is taken by the engine in its idle state. A
// reduction passes the REDUCE state, the one-bit-per-cycle divider in weighted
// mean mode, and the EMIT state, which waits while the receiver stalls; a peak
// that both closes a cluster and ends the frame is reduced twice, the closed
// cluster first and then the frame-end result.
// Reset (synchronous, rst_n low) restores the register defaults, empties the
// queue and closes any cluster. While the receiver stalls, the result register
// holds; the input stage and the two-entry queue keep taking peaks until full.
`default_nettype none
module spectral_peak_cluster_reduce_top
  import spcr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [31:0]     in_tdata,    // [14:0] in_pitch, [30:15] in_volume, [31] zero
  input  wire logic            in_tlast,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [39:0]          out_tdata,   // [14:0] out_pitch, [38:15] out_volume, [39] zero
  output logic                 out_tlast,
  output logic                 out_tuser,   // [0] out_empty
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_addr,
  input  wire logic [CFGW-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  logic   push;
  peak_t  push_item;
  logic   q_ready;
  qhead_t q_head;
  logic   q_pop;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.join_distance <= PW'(102);
      cfg_r.pitch_mode    <= PM_WMEAN;
      cfg_r.volume_mode   <= VM_SUM;
      cfg_r.volume_floor  <= SW'(7);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_JOIN:  cfg_r.join_distance <= cfg_wdata[PW-1:0];
        CFG_PMODE: cfg_r.pitch_mode    <= cfg_wdata[1:0];
        CFG_VMODE: cfg_r.volume_mode   <= cfg_wdata[0];
        CFG_FLOOR: cfg_r.volume_floor  <= cfg_wdata[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  spcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  spcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  spcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

### hdl/spcr_front.sv
// Input stage: takes peak transfers and forms the pitch-volume product.
`default_nettype none
module spcr_front
  import spcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tlast,
  output logic             push,
  output peak_t            push_item,
  input  wire logic        q_ready
);

  logic  fr_valid_r;
  logic  fr_valid_nxt;
  peak_t fr_item_r;
  peak_t fr_item_nxt;
  logic  take;

  assign in_tready = !fr_valid_r || q_ready;
  assign take      = in_tvalid && in_tready;
  assign push      = fr_valid_r && q_ready;
  assign push_item = fr_item_r;

  // Unpack the transfer and multiply pitch by volume
  always_comb begin
    fr_item_nxt        = fr_item_r;
    fr_item_nxt.pitch  = in_tdata[PW-1:0];
    fr_item_nxt.volume = in_tdata[PW+VW-1:PW];
    fr_item_nxt.last   = in_tlast;
    fr_item_nxt.prod   = MW'(in_tdata[PW-1:0]) * MW'(in_tdata[PW+VW-1:PW]);
  end

  // Hold the stage until the queue takes it
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (take) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item_r <= fr_item_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/spcr_queue.sv
// Short queue of prepared peaks between the input stage and the cluster engine.
`default_nettype none
module spcr_queue
  import spcr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire peak_t  push_item,
  output logic        q_ready,
  output qhead_t      q_head,
  input  wire logic   q_pop
);

  peak_t          q_mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic [QAW:0]   cnt_nxt;
  logic           do_pop;

  assign q_ready      = cnt_r != QDEPTH[QAW:0];
  assign q_head.valid = cnt_r != '0;
  assign q_head.item  = q_mem_r[rd_ptr_r];
  assign do_pop       = q_pop && q_head.valid;

  // Track the fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### hdl/spcr_back.sv
// Cluster engine: joins peaks, reduces closed clusters and drives the result port.
`default_nettype none
module spcr_back
  import spcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire qhead_t      q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // [14:0] out_pitch, [38:15] out_volume, [39] zero
  output logic             out_tlast,
  output logic             out_tuser    // [0] out_empty
);

  bk_state_t state_r;
  bk_state_t state_nxt;
  phase_t    phase_r;

  // Open cluster
  logic          open_r;
  logic [PW-1:0] lo_r;
  logic [PW-1:0] hi_r;
  logic [VW-1:0] lv_r;
  logic [PW-1:0] lp_r;
  logic [SW-1:0] vsum_r;
  logic [WW-1:0] wsum_r;

  // Held peak, reduction result and divider
  peak_t           item_r;
  logic [PW-1:0]   res_pitch_r;
  logic [SW-1:0]   res_vol_r;
  logic            res_pass_r;
  logic [SW-1:0]   rem_r;
  logic [PW-1:0]   dq_r;
  logic [CNTW-1:0] cnt_r;

  // Result register
  logic          out_valid_r;
  logic [PW-1:0] out_pitch_r;
  logic [SW-1:0] out_vol_r;
  logic          out_last_r;
  logic          out_empty_r;

  // Control
  logic cu_en;
  logic cu_start_held;
  logic div_init;
  logic div_step;
  logic ld_res;
  logic ld_out;
  logic clr_open;
  logic out_free;
  logic set_phase;
  phase_t phase_nxt;

  // Datapath terms
  peak_t         h;
  peak_t         cu_item;
  logic          cu_start;
  logic [PW-1:0] lo_m;
  logic [PW-1:0] hi_m;
  logic [PW-1:0] span;
  logic          close;
  logic          weighted;
  logic          vsum_zero;
  logic          div_ovf;
  logic          div_go;
  logic [PW:0]   ctr_sum;
  logic [PW-1:0] red_pitch;
  logic [SW-1:0] red_vol;
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          ge;
  logic [SW-1:0] rem_nxt;
  logic [PW-1:0] dq_nxt;
  logic [SW:0]   vadd;
  logic [WW:0]   wadd;

  assign h        = q_head.item;
  assign out_free = !out_valid_r || out_tready;

  // Classify the head peak against the open cluster
  always_comb begin
    lo_m  = (h.pitch < lo_r) ? h.pitch : lo_r;
    hi_m  = (h.pitch > hi_r) ? h.pitch : hi_r;
    span  = hi_m - lo_m;
    close = open_r && (span > cfg.join_distance);
  end

  // Reduce the open cluster
  always_comb begin
    vsum_zero = vsum_r == '0;
    div_ovf   = wsum_r[WW-1:PW] >= vsum_r;
    ctr_sum   = {1'b0, lo_r} + {1'b0, hi_r};
    red_vol   = (cfg.volume_mode == VM_SUM) ? vsum_r : {{(SW-VW){1'b0}}, lv_r};
    weighted  = 1'b0;
    case (cfg.pitch_mode)
      PM_CENTRE: begin
        red_pitch = ctr_sum[PW:1];
      end
      PM_LOUDEST: begin
        red_pitch = lp_r;
      end
      PM_WMEAN: begin
        weighted  = 1'b1;
        red_pitch = vsum_zero ? lo_r : PITCH_MAX;
      end
      default: begin
        weighted  = 1'b1;
        red_pitch = vsum_zero ? lo_r : PITCH_MAX;
      end
    endcase
    div_go = weighted && !vsum_zero && !div_ovf;
  end

  // One restoring division step
  always_comb begin
    trial   = {rem_r, dq_r[PW-1]};
    diff    = trial - {1'b0, vsum_r};
    ge      = trial >= {1'b0, vsum_r};
    rem_nxt = ge ? diff[SW-1:0] : trial[SW-1:0];
    dq_nxt  = {dq_r[PW-2:0], ge};
  end

  // Cluster update source
  always_comb begin
    cu_item  = cu_start_held ? item_r : h;
    cu_start = cu_start_held || !open_r;
    vadd     = {1'b0, vsum_r} + {{(SW-VW+1){1'b0}}, cu_item.volume};
    wadd     = {1'b0, wsum_r} + {{(WW-MW+1){1'b0}}, cu_item.prod};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_head.valid && (close || h.last)) begin
          state_nxt = BK_REDUCE;
        end
      end
      BK_REDUCE: begin
        state_nxt = div_go ? BK_DIV : BK_EMIT;
      end
      BK_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = (phase_r == PH_CLOSE && item_r.last) ? BK_REDUCE : BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop         = 1'b0;
    cu_en         = 1'b0;
    cu_start_held = 1'b0;
    div_init      = 1'b0;
    div_step      = 1'b0;
    ld_res        = 1'b0;
    ld_out        = 1'b0;
    clr_open      = 1'b0;
    set_phase     = 1'b0;
    phase_nxt     = PH_CLOSE;
    case (state_r)
      BK_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          cu_en     = !close;
          set_phase = 1'b1;
          phase_nxt = close ? PH_CLOSE : PH_FINAL;
        end
      end
      BK_REDUCE: begin
        ld_res   = 1'b1;
        div_init = div_go;
      end
      BK_DIV: begin
        div_step = 1'b1;
      end
      BK_EMIT: begin
        if (out_free) begin
          ld_out = res_pass_r || (phase_r == PH_FINAL);
          if (phase_r == PH_CLOSE) begin
            cu_en         = 1'b1;
            cu_start_held = 1'b1;
            set_phase     = item_r.last;
            phase_nxt     = PH_FINAL;
          end else begin
            clr_open = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      phase_r     <= PH_CLOSE;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (set_phase) begin
        phase_r <= phase_nxt;
      end
      if (clr_open) begin
        open_r <= 1'b0;
      end else if (cu_en) begin
        open_r <= 1'b1;
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Open or extend the cluster
  always_ff @(posedge clk) begin
    if (cu_en) begin
      if (cu_start) begin
        lo_r   <= cu_item.pitch;
        hi_r   <= cu_item.pitch;
        lp_r   <= cu_item.pitch;
        lv_r   <= cu_item.volume;
        vsum_r <= {{(SW-VW){1'b0}}, cu_item.volume};
        wsum_r <= {{(WW-MW){1'b0}}, cu_item.prod};
      end else begin
        lo_r <= lo_m;
        hi_r <= hi_m;
        if (cu_item.volume > lv_r) begin
          lv_r <= cu_item.volume;
          lp_r <= cu_item.pitch;
        end
        vsum_r <= vadd[SW] ? '1 : vadd[SW-1:0];
        wsum_r <= wadd[WW] ? '1 : wadd[WW-1:0];
      end
    end
  end

  // Hold the popped peak, reduce and divide
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= h;
    end
    if (ld_res) begin
      res_pitch_r <= red_pitch;
      res_vol_r   <= red_vol;
      res_pass_r  <= red_vol >= cfg.volume_floor;
    end
    if (div_init) begin
      rem_r <= wsum_r[WW-1:PW];
      dq_r  <= wsum_r[PW-1:0];
      cnt_r <= CNTW'(PW - 1);
    end else if (div_step) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        res_pitch_r <= dq_nxt;
      end
    end
  end

  // Load the result register; a dropped final cluster becomes a marker
  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_last_r  <= phase_r == PH_FINAL;
      out_empty_r <= !res_pass_r;
      out_pitch_r <= res_pass_r ? res_pitch_r : '0;
      out_vol_r   <= res_pass_r ? res_vol_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_vol_r, out_pitch_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

  // The remainder stays below the divisor throughout the division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> rem_r < vsum_r)
    else $error("divider remainder not below volume sum");

  // A marker carries the frame end and no cluster data
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r && out_pitch_r == '0 && out_vol_r == '0)
    else $error("marker result malformed");

  // The frame-end result closes the cluster
  a_final_close: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EMIT && out_free && phase_r == PH_FINAL |=> !open_r)
    else $error("cluster left open after frame end");

  // No new peak is taken while a reduction is in flight
  a_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_IDLE |-> !q_pop)
    else $error("queue popped during reduction");

endmodule
`default_nettype wire
